FILE: hw/rtl/gma_pkg.sv
// ----------------------------------------------------------------------------
// gma_pkg
// Shared types and constants of the grid marginal accumulator: field widths,
// item kinds, register indexes and the command and status groups that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package gma_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 12;
  localparam int PROB_W      = 48;
  localparam int COH_W       = 40;
  localparam int RANK_W      = 3;
  localparam int AXSEL_W     = 2;
  localparam int PTS_W       = 11;
  localparam int CFG_AXES    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCUM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RANK        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_AXIS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_AXIS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_AXIS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS0_PTS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS1_PTS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS2_PTS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS3_PTS   = 3'd7;

  localparam logic [PROB_W-1:0] PROB_MAX = {PROB_W{1'b1}};
  localparam logic [COH_W-1:0]  COH_MAX  = {1'b0, {(COH_W-1){1'b1}}};
  localparam logic [COH_W-1:0]  COH_MIN  = {1'b1, {(COH_W-1){1'b0}}};

  typedef struct packed {
    logic [RANK_W-1:0]                rank;
    logic [AXSEL_W-1:0]               first_axis;
    logic [AXSEL_W-1:0]               second_axis;
    logic                             two_axis_mode;
    logic [CFG_AXES-1:0][PTS_W-1:0]   points;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic odo_clear;
    logic clr_write;
    logic acc_mul;
    logic acc_read;
    logic acc_write;
    logic rd_read;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/gma_regs.sv
// ----------------------------------------------------------------------------
// gma_regs
// Configuration registers of the grid marginal accumulator, written through
// a plain write port.
// ----------------------------------------------------------------------------
module gma_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [gma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gma_pkg::CFG_DATA_W-1:0] cfg_data,
  output gma_pkg::cfg_t                 cfg
);
  import gma_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rank          <= RANK_W'(1);
      cfg.first_axis    <= '0;
      cfg.second_axis   <= '0;
      cfg.two_axis_mode <= 1'b0;
      for (int i = 0; i < CFG_AXES; i++) begin
        cfg.points[i] <= PTS_W'(1);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANK:        cfg.rank          <= cfg_data[RANK_W-1:0];
        REG_FIRST_AXIS:  cfg.first_axis    <= cfg_data[AXSEL_W-1:0];
        REG_SECOND_AXIS: cfg.second_axis   <= cfg_data[AXSEL_W-1:0];
        REG_TWO_AXIS:    cfg.two_axis_mode <= cfg_data[0];
        REG_AXIS0_PTS:   cfg.points[0]     <= cfg_data[PTS_W-1:0];
        REG_AXIS1_PTS:   cfg.points[1]     <= cfg_data[PTS_W-1:0];
        REG_AXIS2_PTS:   cfg.points[2]     <= cfg_data[PTS_W-1:0];
        REG_AXIS3_PTS:   cfg.points[3]     <= cfg_data[PTS_W-1:0];
      endcase
    end
  end

endmodule

FILE: hw/rtl/gma_ctrl.sv
// ----------------------------------------------------------------------------
// gma_ctrl
// Controller of the grid marginal accumulator. Sequences the clearing pass,
// the bin read-modify-write of a sample and the bin read.
// ----------------------------------------------------------------------------
module gma_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gma_pkg::KIND_W-1:0] kind,
  input  gma_pkg::stat_t             stat,
  output gma_pkg::cmd_t              cmd
);
  import gma_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_ACC_RD = 3'd3;
  localparam logic [2:0] ST_ACC_WR = 3'd4;
  localparam logic [2:0] ST_RD     = 3'd5;
  localparam logic [2:0] ST_RD_OUT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          unique case (kind)
            KIND_CLEAR: begin
              cmd.odo_clear = 1'b1;
              state_next    = ST_CLEAR;
            end
            KIND_ACCUM: state_next = ST_MUL;
            KIND_READ:  state_next = ST_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        cmd.acc_mul = 1'b1;
        state_next  = ST_ACC_RD;
      end
      ST_ACC_RD: begin
        cmd.acc_read = 1'b1;
        state_next   = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd.acc_write = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_RD: begin
        cmd.rd_read = 1'b1;
        state_next  = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/gma_dp.sv
// ----------------------------------------------------------------------------
// gma_dp
// Datapath of the grid marginal accumulator: coordinate odometer, bin index
// multiplier, squares, bin memory with saturating update and the result
// register.
// ----------------------------------------------------------------------------
module gma_dp #(
  parameter int MAX_AXES   = 4,
  parameter int BINS       = 4096,
  parameter int POINTS_MAX = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gma_pkg::cfg_t                          cfg,
  input  gma_pkg::cmd_t                          cmd,
  output gma_pkg::stat_t                         stat,
  input  logic signed [gma_pkg::SAMPLE_BITS-1:0] psi_re,
  input  logic signed [gma_pkg::SAMPLE_BITS-1:0] psi_im,
  input  logic [gma_pkg::IDX_W-1:0]              read_index,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [gma_pkg::IDX_W-1:0]              bin_index,
  output logic [gma_pkg::PROB_W-1:0]             bin_probability,
  output logic signed [gma_pkg::COH_W-1:0]       coherent_re,
  output logic signed [gma_pkg::COH_W-1:0]       coherent_im
);
  import gma_pkg::*;

  localparam int BIN_W = $clog2(BINS);
  localparam int CW    = $clog2(POINTS_MAX);
  localparam int PW    = $clog2(POINTS_MAX + 1);
  localparam int PRODW = CW + PW;
  localparam int SUMW  = PRODW + 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int MEM_W = PROB_W + 2 * COH_W;

  logic signed [SAMPLE_BITS-1:0] psi_re_q;
  logic signed [SAMPLE_BITS-1:0] psi_im_q;
  logic [IDX_W-1:0]              read_index_q;

  logic [PW-1:0]  points_c [CFG_AXES];
  logic [PW-1:0]  axis_pts [MAX_AXES];
  logic [CW-1:0]  coord [MAX_AXES];
  logic [CW-1:0]  coord_next [MAX_AXES];
  logic [3:0]     used_rank;

  logic [CW-1:0]  x_sel;
  logic [CW-1:0]  y_sel;
  logic [PW-1:0]  mult_b;
  logic [PRODW-1:0] prod;
  logic [CW-1:0]  y_q;
  logic signed [SQ_W-1:0] sq_re;
  logic signed [SQ_W-1:0] sq_im;
  logic [SQ_W-1:0] mag_q;

  logic [SUMW-1:0]  bin_sum;
  logic             bin_ok_now;
  logic             bin_ok_q;
  logic [BIN_W-1:0] bin_addr_q;
  logic             rd_ok_now;
  logic             rd_ok_q;

  logic [MEM_W-1:0] mem [BINS];
  logic [MEM_W-1:0] rd_q;
  logic             mem_rd_en;
  logic [BIN_W-1:0] mem_rd_addr;
  logic             mem_wr_en;
  logic [BIN_W-1:0] mem_wr_addr;
  logic [MEM_W-1:0] mem_wr_data;
  logic [BIN_W-1:0] clr_cnt;

  logic [PROB_W-1:0]      acc_p;
  logic [COH_W-1:0]       acc_re;
  logic [COH_W-1:0]       acc_im;
  logic [PROB_W:0]        p_sum;
  logic [COH_W:0]         re_sum;
  logic [COH_W:0]         im_sum;
  logic [PROB_W-1:0]      p_new;
  logic [COH_W-1:0]       re_new;
  logic [COH_W-1:0]       im_new;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      psi_re_q     <= psi_re;
      psi_im_q     <= psi_im;
      read_index_q <= read_index;
    end
  end

  always_comb begin
    for (int i = 0; i < CFG_AXES; i++) begin
      if (cfg.points[i] == '0) begin
        points_c[i] = PW'(1);
      end else if (32'(cfg.points[i]) > POINTS_MAX) begin
        points_c[i] = PW'(POINTS_MAX);
      end else begin
        points_c[i] = PW'(cfg.points[i]);
      end
    end
  end

  for (genvar d = 0; d < MAX_AXES; d++) begin : g_axis
    if (d < CFG_AXES) begin : g_reg
      assign axis_pts[d] = points_c[d];
    end else begin : g_one
      assign axis_pts[d] = PW'(1);
    end
  end

  always_comb begin
    if (cfg.rank == '0) begin
      used_rank = 4'd1;
    end else if (32'(cfg.rank) > MAX_AXES) begin
      used_rank = 4'(MAX_AXES);
    end else begin
      used_rank = 4'(cfg.rank);
    end
  end

  // The fastest axis is the last one in use; a carry ripples toward axis 0.
  always_comb begin
    logic carry;
    logic in_use;
    logic last;
    carry = 1'b1;
    for (int d = MAX_AXES - 1; d >= 0; d--) begin
      in_use        = 4'(d) < used_rank;
      last          = (32'(coord[d]) + 32'd1) >= 32'(axis_pts[d]);
      coord_next[d] = coord[d];
      if (in_use && carry) begin
        coord_next[d] = last ? '0 : coord[d] + 1'b1;
      end
      carry = carry & (!in_use || last);
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < MAX_AXES; d++) begin
      if (rst || cmd.odo_clear) begin
        coord[d] <= '0;
      end else if (cmd.acc_write) begin
        coord[d] <= coord_next[d];
      end
    end
  end

  always_comb begin
    x_sel = '0;
    y_sel = '0;
    for (int d = 0; d < MAX_AXES; d++) begin
      if (32'(cfg.first_axis) == d) begin
        x_sel = coord[d];
      end
      if (32'(cfg.second_axis) == d) begin
        y_sel = coord[d];
      end
    end
    mult_b = cfg.two_axis_mode ? points_c[cfg.second_axis] : PW'(1);
    if (!cfg.two_axis_mode) begin
      y_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_mul) begin
      prod  <= PRODW'(x_sel) * PRODW'(mult_b);
      y_q   <= y_sel;
      sq_re <= psi_re_q * psi_re_q;
      sq_im <= psi_im_q * psi_im_q;
    end
  end

  assign bin_sum    = SUMW'(prod) + SUMW'(y_q);
  assign bin_ok_now = 64'(bin_sum) < 64'(BINS);
  assign rd_ok_now  = 32'(read_index_q) < BINS;

  always_ff @(posedge clk) begin
    if (cmd.acc_read) begin
      bin_ok_q   <= bin_ok_now;
      bin_addr_q <= BIN_W'(bin_sum);
      mag_q      <= $unsigned(sq_re) + $unsigned(sq_im);
    end
    if (cmd.rd_read) begin
      rd_ok_q <= rd_ok_now;
    end
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = BIN_W'(bin_sum);
    if (cmd.acc_read) begin
      mem_rd_en = bin_ok_now;
    end else if (cmd.rd_read) begin
      mem_rd_en   = rd_ok_now;
      mem_rd_addr = BIN_W'(read_index_q);
    end
  end

  assign acc_p  = rd_q[MEM_W-1 -: PROB_W];
  assign acc_re = rd_q[2*COH_W-1 -: COH_W];
  assign acc_im = rd_q[COH_W-1:0];

  always_comb begin
    p_sum  = {1'b0, acc_p} + (PROB_W+1)'(mag_q);
    re_sum = {acc_re[COH_W-1], acc_re} + (COH_W+1)'(psi_re_q);
    im_sum = {acc_im[COH_W-1], acc_im} + (COH_W+1)'(psi_im_q);
    p_new  = (p_sum >= {1'b0, PROB_MAX}) ? PROB_MAX : p_sum[PROB_W-1:0];
    case (re_sum[COH_W:COH_W-1])
      2'b01:   re_new = COH_MAX;
      2'b10:   re_new = COH_MIN;
      default: re_new = re_sum[COH_W-1:0];
    endcase
    case (im_sum[COH_W:COH_W-1])
      2'b01:   im_new = COH_MAX;
      2'b10:   im_new = COH_MIN;
      default: im_new = im_sum[COH_W-1:0];
    endcase
  end

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = bin_addr_q;
    mem_wr_data = {p_new, re_new, im_new};
    if (cmd.clr_write) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt;
      mem_wr_data = '0;
    end else if (cmd.acc_write) begin
      mem_wr_en = bin_ok_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_q <= mem[mem_rd_addr];
    end
  end

  assign stat.clr_last = (clr_cnt == BIN_W'(BINS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= stat.clr_last ? '0 : clr_cnt + 1'b1;
    end
  end

  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_index       <= read_index_q;
      bin_probability <= rd_ok_q ? acc_p : '0;
      coherent_re     <= rd_ok_q ? acc_re : '0;
      coherent_im     <= rd_ok_q ? acc_im : '0;
    end
  end

endmodule

FILE: hw/rtl/grid_marginal_accumulator.sv
// ----------------------------------------------------------------------------
// grid_marginal_accumulator
// Accumulates squared magnitude and coherent sum of grid samples into
// marginal bins selected by one axis coordinate or by a pair of axes.
// ----------------------------------------------------------------------------
// Samples arrive in row-major order and an internal odometer tracks their
// coordinates. All bins live in one single-port memory, so every item runs
// as a short sequence: a sample beat steps through accept, index multiply
// and squares, bin read and saturating write back; a read beat through
// accept, bin read and result load, which waits for the result register to
// drain; a clear beat through accept and a sweep of the memory to zero, one
// bin per cycle. After reset the same sweep runs before the first beat is
// taken; configuration writes are accepted at any time but must only be
// issued while the block is idle.
module grid_marginal_accumulator #(
  parameter int MAX_AXES   = 4,
  parameter int BINS       = 4096,
  parameter int POINTS_MAX = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [gma_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [gma_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [gma_pkg::KIND_W-1:0]             kind,
  input  logic signed [gma_pkg::SAMPLE_BITS-1:0] psi_re,
  input  logic signed [gma_pkg::SAMPLE_BITS-1:0] psi_im,
  input  logic [gma_pkg::IDX_W-1:0]              read_index,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [gma_pkg::IDX_W-1:0]              bin_index,
  output logic [gma_pkg::PROB_W-1:0]             bin_probability,
  output logic signed [gma_pkg::COH_W-1:0]       coherent_re,
  output logic signed [gma_pkg::COH_W-1:0]       coherent_im
);
  import gma_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  gma_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  gma_dp #(
    .MAX_AXES   (MAX_AXES),
    .BINS       (BINS),
    .POINTS_MAX (POINTS_MAX)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .psi_re          (psi_re),
    .psi_im          (psi_im),
    .read_index      (read_index),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .bin_index       (bin_index),
    .bin_probability (bin_probability),
    .coherent_re     (coherent_re),
    .coherent_im     (coherent_im)
  );

endmodule
